/* src/askf_pkg.sv */
// Shared types, constants and saturating arithmetic helpers for the adaptive
// scalar Kalman filter. Depends on nothing; used by askf_mul and the filter top level.
package askf_pkg;

    typedef logic signed [63:0] s64_t;

    // Sequencer states of the filter datapath.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_DZ,
        ST_GAIN,
        ST_KDZ,
        ST_COV,
        ST_POW,
        ST_DK,
        ST_BIAS,
        ST_DRIFT,
        ST_EE,
        ST_MEAS,
        ST_KE,
        ST_KEKE,
        ST_PROC,
        ST_MEAN,
        ST_D2,
        ST_VAR,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Right shift applied to a finished product.
    typedef enum logic [1:0] {
        SH_FRAC,
        SH_32,
        SH_16
    } shsel_t;

    typedef struct packed {
        logic   start;
        shsel_t sh;
    } mul_req_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_PNOISE = 2'd1;
    localparam logic [1:0] CFG_MNOISE = 2'd2;
    localparam logic [1:0] CFG_FORGET = 2'd3;

    localparam logic [47:0] NOISE_RST  = 48'd42950;
    localparam logic [15:0] FORGET_RST = 16'd64881;
    localparam logic [31:0] POW_RST    = 32'hFFFF_FFFF;
    localparam logic [47:0] MASK48     = 48'hFFFF_FFFF_FFFF;
    localparam s64_t        S64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam s64_t        S64_MIN    = 64'sh8000_0000_0000_0000;
    localparam s64_t        DK_ONE     = 64'sh0000_0001_0000_0000;

    function automatic logic [63:0] mag(input s64_t v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Signed value from a magnitude and a sign, saturated to 64 bits.
    function automatic s64_t from_mag(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m > 64'h8000_0000_0000_0000) begin
                return S64_MIN;
            end
            return s64_t'(-m);
        end
        if (m[63]) begin
            return S64_MAX;
        end
        return s64_t'(m);
    endfunction

    function automatic s64_t sadd(input s64_t a, input s64_t b);
        s64_t s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    function automatic s64_t ssub(input s64_t a, input s64_t b);
        s64_t d;
        d = a - b;
        if ((a[63] != b[63]) && (d[63] != a[63])) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return d;
    endfunction

    function automatic logic [47:0] clamp48(input s64_t v);
        if (v[63]) begin
            return 48'd0;
        end
        if (|v[62:48]) begin
            return MASK48;
        end
        return v[47:0];
    endfunction

endpackage

/* src/askf_mul.sv */
// Bit-serial 64 x 64 magnitude multiplier with a selectable right shift and
// signed saturation of the result. Depends on askf_pkg.
module askf_mul #(
    parameter int FRAC_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  askf_pkg::mul_req_t req_i,
    input  askf_pkg::s64_t    a_i,
    input  askf_pkg::s64_t    b_i,
    output logic              done_o,
    output askf_pkg::s64_t    res_o
);

    localparam logic [5:0] LAST_STEP = 6'd63;

    logic                busy_reg;
    logic                fin_reg;
    logic                done_reg;
    logic [5:0]          cnt_reg;
    logic [63:0]         mcand_reg;
    logic [127:0]        prod_reg;
    logic                neg_reg;
    askf_pkg::shsel_t    sh_reg;
    askf_pkg::s64_t      res_reg;

    logic [64:0]  sum;
    logic [127:0] shifted;
    logic [63:0]  mag_sat;

    // One multiplier bit per cycle: add the multiplicand into the upper half,
    // then shift the whole product right.
    assign sum = {1'b0, prod_reg[127:64]} + (prod_reg[0] ? {1'b0, mcand_reg} : 65'd0);

    always_comb begin
        case (sh_reg)
            askf_pkg::SH_FRAC: shifted = prod_reg >> FRAC_BITS;
            askf_pkg::SH_32:   shifted = prod_reg >> 32;
            askf_pkg::SH_16:   shifted = prod_reg >> 16;
            default:           shifted = prod_reg;
        endcase
        mag_sat = (|shifted[127:64]) ? {64{1'b1}} : shifted[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
            if (req_i.start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= 6'd0;
                mcand_reg <= askf_pkg::mag(a_i);
                prod_reg  <= {64'd0, askf_pkg::mag(b_i)};
                neg_reg   <= a_i[63] ^ b_i[63];
                sh_reg    <= req_i.sh;
            end else if (busy_reg) begin
                prod_reg <= {sum, prod_reg[63:1]};
                cnt_reg  <= cnt_reg + 6'd1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                res_reg <= askf_pkg::from_mag(mag_sat, neg_reg);
            end
        end
    end

    assign done_o = done_reg;
    assign res_o  = res_reg;

endmodule

/* src/askf_div.sv */
// Restoring bit-serial divider: 128-bit unsigned dividend by 64-bit divisor,
// one quotient bit per cycle. Depends on nothing.
module askf_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start_i,
    input  logic [127:0] num_i,
    input  logic [63:0]  den_i,
    output logic         done_o,
    output logic [63:0]  quo_o
);

    localparam logic [6:0] LAST_STEP = 7'd127;

    logic         busy_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] num_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  den_reg;

    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, num_reg[127]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
                num_reg  <= num_i;
                rem_reg  <= 64'd0;
                den_reg  <= den_i;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_sub[63:0] : rem_sh[63:0];
                num_reg <= {num_reg[126:0], ge};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done_o = done_reg;
    assign quo_o  = num_reg[63:0];

endmodule

/* src/adaptive_scalar_kalman_filter.sv */
// Adaptive scalar Kalman filter for clock-offset samples. Each input transaction carries a
// signed offset and an unsigned path delay; each produces exactly one output transaction
// with the filtered offset in whole nanoseconds, truncated toward zero and saturated to
// 48 bits. Mode 0 runs a fixed-noise filter; mode 1 runs a Sage-Husa adaptive filter that
// tracks bias, drift and both noise terms and adds the running delay variance to the
// measurement noise. All arithmetic is done by one bit-serial multiplier and one
// bit-serial divider under a sequencer; a transaction uses at most one division and two
// products in mode 0 and at most four divisions and eleven products in mode 1. One item
// is processed at a time; a finished result sits in an output register, so the next
// input is taken while it waits. The user must write configuration only while the block
// is idle; the block itself does not enforce this.
module adaptive_scalar_kalman_filter #(
    parameter int FRAC_BITS  = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [47:0] s_offset_sample,
    input  logic [31:0]        s_delay_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_filtered_offset,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_wdata
);

    localparam askf_pkg::s64_t ONE_Q = askf_pkg::s64_t'(64'd1 << FRAC_BITS);
    // Largest integer that still fits once scaled by one.
    localparam askf_pkg::s64_t Q_LIM = askf_pkg::S64_MAX >>> FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam askf_pkg::s64_t OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam askf_pkg::s64_t OUT_MIN = -64'sh0000_8000_0000_0000;

    // Configuration registers.
    logic        mode_reg;
    logic [47:0] pn_reg;
    logic [47:0] mn_reg;
    logic [15:0] b_reg;

    // Filter state.
    askf_pkg::s64_t          est_reg;
    logic [47:0]             p_reg;
    askf_pkg::s64_t          bias_reg;
    askf_pkg::s64_t          drift_reg;
    logic [47:0]             aq_reg;
    logic [47:0]             ar_reg;
    logic [47:0]             rr_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic [31:0]             pow_reg;
    askf_pkg::s64_t          mean_reg;
    askf_pkg::s64_t          var_reg;

    // Working values of the transaction in flight.
    askf_pkg::s64_t zq_reg, dq_reg, xp_reg, dz_reg, e_reg, k_reg, x_reg;
    askf_pkg::s64_t dk_reg, ke_reg, tmp_reg, d1_reg;

    // Sequencer.
    askf_pkg::state_t state_reg, state_next;
    logic             go_reg, go_next;

    logic               m_valid_reg;
    logic signed [47:0] out_reg;

    // Arithmetic units.
    askf_pkg::mul_req_t mul_req;
    askf_pkg::s64_t     mul_a, mul_b, mul_res;
    logic               mul_done;
    logic               div_start, div_done;
    logic [127:0]       div_num;
    logic [63:0]        div_den, div_quo;

    askf_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (mul_req),
        .a_i     (mul_a),
        .b_i     (mul_b),
        .done_o  (mul_done),
        .res_o   (mul_res)
    );

    askf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .num_i   (div_num),
        .den_i   (div_den),
        .done_o  (div_done),
        .quo_o   (div_quo)
    );

    // Input scaling to fixed point, saturated.
    askf_pkg::s64_t z64, d64, zq_in, dq_in;
    assign z64 = {{16{s_offset_sample[47]}}, s_offset_sample};
    assign d64 = {32'd0, s_delay_sample};

    always_comb begin
        if (z64 > Q_LIM) begin
            zq_in = askf_pkg::S64_MAX;
        end else if (z64 < -Q_LIM - 64'sd1) begin
            zq_in = askf_pkg::S64_MIN;
        end else begin
            zq_in = z64 <<< FRAC_BITS;
        end
        if (d64 > Q_LIM) begin
            dq_in = askf_pkg::S64_MAX;
        end else begin
            dq_in = d64 <<< FRAC_BITS;
        end
    end

    // Shared datapath terms.
    logic [48:0]    gain_den;
    logic [32:0]    dk_num, dk_den;
    askf_pkg::s64_t mean_diff, var_diff, div_signed, var_sum;
    logic           div_neg;
    logic [47:0]    p_sum_clamp;
    logic [48:0]    p_sum;

    assign gain_den  = {1'b0, p_reg} + {1'b0, (mode_reg ? rr_reg : mn_reg)};
    assign dk_num    = 33'(17'h10000 - {1'b0, b_reg}) << 16;
    assign dk_den    = 33'h1_0000_0000 - {1'b0, pow_reg};
    assign mean_diff = askf_pkg::ssub(dq_reg, mean_reg);
    assign var_diff  = askf_pkg::ssub(tmp_reg, var_reg);
    assign div_neg   = (state_reg == askf_pkg::ST_MEAN) ? mean_diff[63] : var_diff[63];
    assign div_signed = div_neg ? askf_pkg::s64_t'(-div_quo) : askf_pkg::s64_t'(div_quo);
    assign var_sum   = askf_pkg::sadd(var_reg, div_signed);
    assign p_sum     = {1'b0, p_reg} + {1'b0, (mode_reg ? aq_reg : pn_reg)};
    assign p_sum_clamp = p_sum[48] ? askf_pkg::MASK48 : p_sum[47:0];

    // Truncation toward zero of the fixed-point estimate.
    askf_pkg::s64_t x_int, x_trunc, est_int;
    assign x_int   = (x_reg >>> FRAC_BITS)
                   + askf_pkg::s64_t'({63'd0, x_reg[63] & (|x_reg[FRAC_BITS-1:0])});
    assign x_trunc = x_int <<< FRAC_BITS;
    assign est_int = (est_reg >>> FRAC_BITS)
                   + askf_pkg::s64_t'({63'd0, est_reg[63] & (|est_reg[FRAC_BITS-1:0])});

    logic load_out;
    assign load_out = (state_reg == askf_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    // Sequencer: state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= askf_pkg::ST_IDLE;
            go_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    // Sequencer: next state, unit requests and operand selection. A unit is
    // started in the first cycle of its state and the state is left when the
    // unit reports done; a state whose operation is not needed is left without starting it.
    always_comb begin
        state_next  = state_reg;
        mul_req     = '{start: 1'b0, sh: askf_pkg::SH_FRAC};
        mul_a       = k_reg;
        mul_b       = dz_reg;
        div_start   = 1'b0;
        div_num     = 128'(p_reg) << FRAC_BITS;
        div_den     = 64'(gain_den);
        s_ready     = 1'b0;

        unique case (state_reg)
            askf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = askf_pkg::ST_PREP;
                end
            end
            askf_pkg::ST_PREP: state_next = askf_pkg::ST_DZ;
            askf_pkg::ST_DZ:   state_next = askf_pkg::ST_GAIN;
            askf_pkg::ST_GAIN: begin
                if (gain_den == 49'd0) begin
                    state_next = askf_pkg::ST_KDZ;
                end else begin
                    div_start = !go_reg;
                    if (div_done) begin
                        state_next = askf_pkg::ST_KDZ;
                    end
                end
            end
            askf_pkg::ST_KDZ: begin
                mul_req.start = !go_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_COV;
                end
            end
            askf_pkg::ST_COV: begin
                mul_req.start = !go_reg;
                mul_a = askf_pkg::s64_t'({16'd0, p_reg});
                mul_b = ONE_Q - k_reg;
                if (mul_done) begin
                    state_next = mode_reg ? askf_pkg::ST_POW : askf_pkg::ST_FINISH;
                end
            end
            askf_pkg::ST_POW: begin
                mul_req.sh = askf_pkg::SH_16;
                mul_a = askf_pkg::s64_t'({32'd0, pow_reg});
                mul_b = askf_pkg::s64_t'({48'd0, b_reg});
                if (cnt_reg == CNT_ONE) begin
                    state_next = askf_pkg::ST_DK;
                end else begin
                    mul_req.start = !go_reg;
                    if (mul_done) begin
                        state_next = askf_pkg::ST_DK;
                    end
                end
            end
            askf_pkg::ST_DK: begin
                div_num = 128'(dk_num) << 32;
                div_den = 64'(dk_den);
                if (dk_num >= dk_den) begin
                    state_next = askf_pkg::ST_BIAS;
                end else begin
                    div_start = !go_reg;
                    if (div_done) begin
                        state_next = askf_pkg::ST_BIAS;
                    end
                end
            end
            askf_pkg::ST_BIAS: begin
                mul_req = '{start: !go_reg, sh: askf_pkg::SH_32};
                mul_a = askf_pkg::ssub(dz_reg, bias_reg);
                mul_b = dk_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_DRIFT;
                end
            end
            askf_pkg::ST_DRIFT: begin
                mul_req = '{start: !go_reg, sh: askf_pkg::SH_32};
                mul_a = askf_pkg::ssub(tmp_reg, drift_reg);
                mul_b = dk_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_EE;
                end
            end
            askf_pkg::ST_EE: begin
                mul_req.start = !go_reg;
                mul_a = e_reg;
                mul_b = e_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_MEAS;
                end
            end
            askf_pkg::ST_MEAS: begin
                mul_req = '{start: !go_reg, sh: askf_pkg::SH_32};
                mul_a = askf_pkg::ssub(tmp_reg, askf_pkg::s64_t'({16'd0, ar_reg}));
                mul_b = dk_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_KE;
                end
            end
            askf_pkg::ST_KE: begin
                mul_req.start = !go_reg;
                mul_a = k_reg;
                mul_b = e_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_KEKE;
                end
            end
            askf_pkg::ST_KEKE: begin
                mul_req.start = !go_reg;
                mul_a = ke_reg;
                mul_b = ke_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_PROC;
                end
            end
            askf_pkg::ST_PROC: begin
                mul_req = '{start: !go_reg, sh: askf_pkg::SH_32};
                mul_a = askf_pkg::ssub(tmp_reg, askf_pkg::s64_t'({16'd0, aq_reg}));
                mul_b = dk_reg;
                if (mul_done) begin
                    state_next = askf_pkg::ST_MEAN;
                end
            end
            askf_pkg::ST_MEAN: begin
                div_start = !go_reg;
                div_num = 128'(askf_pkg::mag(mean_diff));
                div_den = 64'(cnt_reg);
                if (div_done) begin
                    state_next = askf_pkg::ST_D2;
                end
            end
            askf_pkg::ST_D2: begin
                mul_req.start = !go_reg;
                mul_a = d1_reg;
                mul_b = mean_diff;
                if (mul_done) begin
                    state_next = askf_pkg::ST_VAR;
                end
            end
            askf_pkg::ST_VAR: begin
                div_start = !go_reg;
                div_num = 128'(askf_pkg::mag(var_diff));
                div_den = 64'(cnt_reg);
                if (div_done) begin
                    state_next = askf_pkg::ST_FINISH;
                end
            end
            askf_pkg::ST_FINISH: state_next = askf_pkg::ST_OUT;
            askf_pkg::ST_OUT: begin
                if (load_out) begin
                    state_next = askf_pkg::ST_IDLE;
                end
            end
            default: state_next = askf_pkg::ST_IDLE;
        endcase

        if (mul_req.start || div_start) begin
            go_next = 1'b1;
        end else if (mul_done || div_done) begin
            go_next = 1'b0;
        end else begin
            go_next = go_reg;
        end
    end

    // Datapath registers. Each unit result is folded into the filter state in
    // the cycle the unit reports done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            pn_reg    <= askf_pkg::NOISE_RST;
            mn_reg    <= askf_pkg::NOISE_RST;
            b_reg     <= askf_pkg::FORGET_RST;
            est_reg   <= '0;
            p_reg     <= '0;
            bias_reg  <= '0;
            drift_reg <= '0;
            aq_reg    <= askf_pkg::NOISE_RST;
            ar_reg    <= askf_pkg::NOISE_RST;
            rr_reg    <= '0;
            cnt_reg   <= '0;
            pow_reg   <= askf_pkg::POW_RST;
            mean_reg  <= '0;
            var_reg   <= '0;
        end else begin
            unique case (state_reg)
                askf_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        zq_reg <= zq_in;
                        dq_reg <= dq_in;
                    end
                end
                askf_pkg::ST_PREP: begin
                    p_reg <= p_sum_clamp;
                    if (mode_reg) begin
                        xp_reg <= askf_pkg::sadd(est_reg, drift_reg);
                        if (cnt_reg != CNT_MAX) begin
                            cnt_reg <= cnt_reg + CNT_ONE;
                        end
                    end else begin
                        xp_reg <= est_reg;
                    end
                end
                askf_pkg::ST_DZ: dz_reg <= askf_pkg::ssub(zq_reg, xp_reg);
                askf_pkg::ST_GAIN: begin
                    e_reg <= askf_pkg::ssub(dz_reg, bias_reg);
                    if (gain_den == 49'd0) begin
                        k_reg <= '0;
                    end else if (div_done) begin
                        k_reg <= (div_quo > 64'(ONE_Q)) ? ONE_Q : askf_pkg::s64_t'(div_quo);
                    end
                end
                askf_pkg::ST_KDZ: begin
                    if (mul_done) begin
                        x_reg <= askf_pkg::sadd(xp_reg, mul_res);
                    end
                end
                askf_pkg::ST_COV: begin
                    if (mul_done) begin
                        p_reg <= askf_pkg::clamp48(mul_res);
                    end
                end
                askf_pkg::ST_POW: begin
                    // Drift target, kept for the drift update further on.
                    tmp_reg <= askf_pkg::ssub(x_reg, est_reg);
                    if (cnt_reg == CNT_ONE) begin
                        pow_reg <= {b_reg, 16'd0};
                    end else if (mul_done) begin
                        pow_reg <= mul_res[31:0];
                    end
                end
                askf_pkg::ST_DK: begin
                    if (dk_num >= dk_den) begin
                        dk_reg <= askf_pkg::DK_ONE;
                    end else if (div_done) begin
                        dk_reg <= askf_pkg::s64_t'(div_quo);
                    end
                end
                askf_pkg::ST_BIAS: begin
                    if (mul_done) begin
                        bias_reg <= askf_pkg::sadd(bias_reg, mul_res);
                    end
                end
                askf_pkg::ST_DRIFT: begin
                    if (mul_done) begin
                        drift_reg <= askf_pkg::sadd(drift_reg, mul_res);
                    end
                end
                askf_pkg::ST_EE: begin
                    if (mul_done) begin
                        tmp_reg <= askf_pkg::ssub(mul_res, askf_pkg::s64_t'({16'd0, p_reg}));
                    end
                end
                askf_pkg::ST_MEAS: begin
                    if (mul_done) begin
                        ar_reg <= askf_pkg::clamp48(
                            askf_pkg::sadd(askf_pkg::s64_t'({16'd0, ar_reg}), mul_res));
                    end
                end
                askf_pkg::ST_KE: begin
                    if (mul_done) begin
                        ke_reg <= mul_res;
                    end
                end
                askf_pkg::ST_KEKE: begin
                    if (mul_done) begin
                        tmp_reg <= mul_res;
                    end
                end
                askf_pkg::ST_PROC: begin
                    if (mul_done) begin
                        aq_reg <= askf_pkg::clamp48(
                            askf_pkg::sadd(askf_pkg::s64_t'({16'd0, aq_reg}), mul_res));
                    end
                end
                askf_pkg::ST_MEAN: begin
                    d1_reg <= mean_diff;
                    if (div_done) begin
                        mean_reg <= askf_pkg::sadd(mean_reg, div_signed);
                    end
                end
                askf_pkg::ST_D2: begin
                    if (mul_done) begin
                        tmp_reg <= mul_res;
                    end
                end
                askf_pkg::ST_VAR: begin
                    if (div_done) begin
                        var_reg <= var_sum[63] ? '0 : var_sum;
                    end
                end
                askf_pkg::ST_FINISH: begin
                    if (mode_reg) begin
                        est_reg <= x_reg;
                        rr_reg  <= askf_pkg::clamp48(
                            askf_pkg::sadd(askf_pkg::s64_t'({16'd0, ar_reg}), var_reg));
                    end else begin
                        est_reg <= x_trunc;
                    end
                end
                askf_pkg::ST_OUT: begin
                end
                default: begin
                end
            endcase

            // The user must write configuration only while idle (not enforced). Until the
            // first adaptive sample the noise registers also seed the adaptive noise.
            if (cfg_we) begin
                unique case (cfg_index)
                    askf_pkg::CFG_MODE: mode_reg <= cfg_wdata[0];
                    askf_pkg::CFG_PNOISE: begin
                        pn_reg <= cfg_wdata;
                        if (cnt_reg == '0) begin
                            aq_reg <= cfg_wdata;
                        end
                    end
                    askf_pkg::CFG_MNOISE: begin
                        mn_reg <= cfg_wdata;
                        if (cnt_reg == '0) begin
                            ar_reg <= cfg_wdata;
                        end
                    end
                    askf_pkg::CFG_FORGET: b_reg <= cfg_wdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: holds a finished transaction while the next is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (est_int > OUT_MAX) begin
                out_reg <= 48'sh7FFF_FFFF_FFFF;
            end else if (est_int < OUT_MIN) begin
                out_reg <= -48'sh8000_0000_0000;
            end else begin
                out_reg <= est_int[47:0];
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_filtered_offset = out_reg;

    // The gain never exceeds one once it has been computed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == askf_pkg::ST_KDZ) |-> (k_reg <= ONE_Q))
        else $error("gain above one");

    // The forgetting weight is limited to one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == askf_pkg::ST_BIAS) |-> (dk_reg <= askf_pkg::DK_ONE))
        else $error("forgetting weight above one");

    // The two arithmetic units are never both finishing at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");

    // No unit is left running when the sequencer returns to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == askf_pkg::ST_IDLE) |-> !go_reg)
        else $error("arithmetic unit busy while idle");

endmodule
